### hdl/fcrw_pkg.sv
// ----------------------------------------------------------------------------
// fcrw_pkg: shared types and codes for the cluster chain run walker
// Operation and status codes, controller states, command and status bundles.
// ----------------------------------------------------------------------------
package fcrw_pkg;

  localparam int unsigned IDX_W    = 12;
  localparam int unsigned ENTRY_W  = 32;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 3;

  localparam logic [ENTRY_W-1:0] END_MARKER_RESET = 32'h0FFF_FFF8;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_NEXT  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_MORE     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FINAL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic wr_entry;   // write table entry from request payload
    logic start_run;  // begin a walk at the requested cluster
    logic start_out;  // start outside the table: result is an error
    logic next_idle;  // continue with no walk: result is idle status
    logic next_run;   // begin the next run at the pending cluster
    logic rd_entry;   // read the entry at the current cluster
    logic eval;       // apply the decision on the read entry
    logic emit;       // move the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start_ok;     // requested cluster lies inside the table
    logic walk_active;  // a walk is in progress
    logic run_end;      // the entry just read ends the run
    logic slot_free;    // output register can take a result this cycle
  } stat_t;

endpackage

### hdl/fcrw_req_if.sv
// ----------------------------------------------------------------------------
// fcrw_req_if: request channel
// Valid/ready channel carrying one table write, start or continue request.
// ----------------------------------------------------------------------------
interface fcrw_req_if;
  logic                            valid;
  logic                            ready;
  logic [fcrw_pkg::OP_W-1:0]       operation;
  logic [fcrw_pkg::IDX_W-1:0]      cluster_index;
  logic [fcrw_pkg::ENTRY_W-1:0]    entry_value;

  modport source (output valid, output operation, output cluster_index,
                  output entry_value, input ready);
  modport sink   (input valid, input operation, input cluster_index,
                  input entry_value, output ready);
endinterface

### hdl/fcrw_rsp_if.sv
// ----------------------------------------------------------------------------
// fcrw_rsp_if: result channel
// Valid/ready channel carrying one reported run and its status.
// ----------------------------------------------------------------------------
interface fcrw_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [fcrw_pkg::IDX_W-1:0]      run_first;
  logic [fcrw_pkg::IDX_W-1:0]      run_last;
  logic [fcrw_pkg::STATUS_W-1:0]   status;

  modport source (output valid, output run_first, output run_last,
                  output status, input ready);
  modport sink   (input valid, input run_first, input run_last,
                  input status, output ready);
endinterface

### hdl/fat_chain_range_walker_top.sv
// ----------------------------------------------------------------------------
// fat_chain_range_walker_top: FAT32 cluster chain run walker
// Stores an allocation table and reports runs of consecutive clusters.
// ----------------------------------------------------------------------------
// Table write: no result; writes stream one per cycle while the controller is
// idle. Start/continue over a run of N clusters: one read and one decide step
// per cluster, then the result is loaded into the output register; the next
// request is taken only after that load. Start outside the table or continue
// with no walk: no table read, the result goes straight to the output
// register. A full output register holds the walk.
// Reset (rst, synchronous): no walk active, end marker 0x0FFFFFF8, output
// empty; table contents stay undefined until written.
// ----------------------------------------------------------------------------
module fat_chain_range_walker_top #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  fcrw_req_if.sink                     req,
  fcrw_rsp_if.source                   rsp,
  input  logic                         cfg_we,
  input  logic [fcrw_pkg::ENTRY_W-1:0] cfg_wdata
);
  import fcrw_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Controller: accept a request beat only while idle, then walk the chain
  // one cluster per read/decide pair and hand the result to the output
  // register. The next request is taken while that result still waits.
  fcrw_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req.valid),
    .req_operation (req.operation),
    .req_ready     (req.ready),
    .stat          (stat),
    .cmd           (cmd)
  );

  // Datapath: table memory, walk registers, link decision, output register.
  fcrw_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .req_cluster_index (req.cluster_index),
    .req_entry_value   (req.entry_value),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .cmd               (cmd),
    .stat              (stat),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_run_first     (rsp.run_first),
    .rsp_run_last      (rsp.run_last),
    .rsp_status        (rsp.status)
  );

endmodule

### hdl/fcrw_ctrl.sv
// ----------------------------------------------------------------------------
// fcrw_ctrl: walk controller
// Sequences request decode, table reads, link decisions and result hand-off.
// ----------------------------------------------------------------------------
module fcrw_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  input  logic [fcrw_pkg::OP_W-1:0] req_operation,
  output logic                      req_ready,
  input  fcrw_pkg::stat_t           stat,
  output fcrw_pkg::cmd_t            cmd
);
  import fcrw_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req_operation == OP_START) begin
            state_next = stat.start_ok ? S_READ : S_EMIT;
          end else if (req_operation == OP_NEXT) begin
            state_next = stat.walk_active ? S_READ : S_EMIT;
          end
        end
      end
      S_READ: state_next = S_EVAL;
      S_EVAL: state_next = stat.run_end ? S_EMIT : S_READ;
      S_EMIT: begin
        if (stat.slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.wr_entry  = (req_operation == OP_WRITE);
          cmd.start_run = (req_operation == OP_START) && stat.start_ok;
          cmd.start_out = (req_operation == OP_START) && !stat.start_ok;
          cmd.next_run  = (req_operation == OP_NEXT) && stat.walk_active;
          cmd.next_idle = (req_operation == OP_NEXT) && !stat.walk_active;
        end
      end
      S_READ: cmd.rd_entry = 1'b1;
      S_EVAL: cmd.eval = 1'b1;
      S_EMIT: cmd.emit = stat.slot_free;
      default: cmd = '0;
    endcase
  end

endmodule

### hdl/fcrw_dp.sv
// ----------------------------------------------------------------------------
// fcrw_dp: walk datapath
// Allocation table memory, walk registers, link decision and output register.
// ----------------------------------------------------------------------------
module fcrw_dp #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [fcrw_pkg::IDX_W-1:0]    req_cluster_index,
  input  logic [fcrw_pkg::ENTRY_W-1:0]  req_entry_value,
  input  logic                          cfg_we,
  input  logic [fcrw_pkg::ENTRY_W-1:0]  cfg_wdata,
  input  fcrw_pkg::cmd_t                cmd,
  output fcrw_pkg::stat_t               stat,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [fcrw_pkg::IDX_W-1:0]    rsp_run_first,
  output logic [fcrw_pkg::IDX_W-1:0]    rsp_run_last,
  output logic [fcrw_pkg::STATUS_W-1:0] rsp_status
);
  import fcrw_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned SW = $clog2(TABLE_DEPTH + 1);
  localparam logic [ENTRY_W-1:0] DEPTH_W = ENTRY_W'(TABLE_DEPTH);

  logic [ENTRY_W-1:0]  table_mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0]  rdata;
  logic [ENTRY_W-1:0]  end_marker_min;
  logic [AW-1:0]       cur;
  logic [AW-1:0]       first;
  logic [AW-1:0]       pending;
  logic                walk_active;
  logic [SW-1:0]       steps;
  logic [IDX_W-1:0]    res_first;
  logic [IDX_W-1:0]    res_last;
  logic [STATUS_W-1:0] res_status;

  logic idx_in_table;
  logic is_end;
  logic is_out;
  logic too_long;
  logic discont;

  assign idx_in_table = (ENTRY_W'(req_cluster_index) < DEPTH_W);
  assign is_end       = (rdata >= end_marker_min);
  assign is_out       = (rdata >= DEPTH_W);
  assign too_long     = (ENTRY_W'(steps) >= DEPTH_W);
  assign discont      = (rdata != (ENTRY_W'(cur) + ENTRY_W'(1)));

  assign stat.start_ok    = idx_in_table;
  assign stat.walk_active = walk_active;
  assign stat.run_end     = is_end || is_out || too_long || discont;
  assign stat.slot_free   = !rsp_valid || rsp_ready;

  // Table memory: one write port from requests, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_entry && idx_in_table) begin
      table_mem[AW'(req_cluster_index)] <= req_entry_value;
    end
    if (cmd.rd_entry) begin
      rdata <= table_mem[cur];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      end_marker_min <= END_MARKER_RESET;
    end else if (cfg_we) begin
      end_marker_min <= cfg_wdata;
    end
  end

  // Walk control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_active <= 1'b0;
      steps       <= '0;
      pending     <= '0;
    end else begin
      if (cmd.start_run) begin
        walk_active <= 1'b1;
        steps       <= '0;
        pending     <= AW'(req_cluster_index);
      end else if (cmd.start_out) begin
        walk_active <= 1'b0;
        steps       <= '0;
        pending     <= '0;
      end else if (cmd.rd_entry) begin
        steps <= steps + SW'(1);
      end else if (cmd.eval) begin
        if (is_end || is_out || too_long) begin
          walk_active <= 1'b0;
        end else if (discont) begin
          pending <= AW'(rdata);
        end
      end
    end
  end

  // Run position and pending result
  always_ff @(posedge clk) begin
    if (cmd.start_run) begin
      first <= AW'(req_cluster_index);
      cur   <= AW'(req_cluster_index);
    end else if (cmd.next_run) begin
      first <= pending;
      cur   <= pending;
    end else if (cmd.eval && !(is_end || is_out || too_long || discont)) begin
      cur <= AW'(rdata);
    end

    if (cmd.start_out) begin
      res_first  <= req_cluster_index;
      res_last   <= req_cluster_index;
      res_status <= ST_OUTSIDE;
    end else if (cmd.next_idle) begin
      res_first  <= '0;
      res_last   <= '0;
      res_status <= ST_IDLE;
    end else if (cmd.eval) begin
      res_first <= IDX_W'(first);
      res_last  <= IDX_W'(cur);
      if (is_end) begin
        res_status <= ST_FINAL;
      end else if (is_out) begin
        res_status <= ST_OUTSIDE;
      end else if (too_long) begin
        res_status <= ST_TOO_LONG;
      end else begin
        res_status <= ST_MORE;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp_run_first <= res_first;
      rsp_run_last  <= res_last;
      rsp_status    <= res_status;
    end
  end

endmodule
